// ===== src/lfsl_pkg.sv =====
// ----------------------------------------------------------------------------
// lfsl_pkg
// shared types and constants of the line follower steering and speed loop
// ----------------------------------------------------------------------------
package lfsl_pkg;

  localparam int PWM_MAX_DEF  = 999;
  localparam int ADC_BITS_DEF = 12;

  localparam int DEADBAND_Q15 = 983;
  localparam int THRESH_Q15   = 13108;
  localparam int INTEG_LIMIT  = 1000;
  localparam int DELTA_LIMIT  = 15 * 256;

  localparam logic [2:0] REG_BASE_SPEED  = 3'd0;
  localparam logic [2:0] REG_SERVO_CTR   = 3'd1;
  localparam logic [2:0] REG_SERVO_LO    = 3'd2;
  localparam logic [2:0] REG_SERVO_HI    = 3'd3;
  localparam logic [2:0] REG_STEER_KP    = 3'd4;
  localparam logic [2:0] REG_STEER_KD    = 3'd5;
  localparam logic [2:0] REG_SPEED_KP    = 3'd6;
  localparam logic [2:0] REG_SPEED_KI    = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERR,
    ST_STEER_P,
    ST_STEER_D,
    ST_SERVO,
    ST_WHEEL_L_P,
    ST_WHEEL_L_I,
    ST_WHEEL_R_P,
    ST_WHEEL_R_I,
    ST_OUT
  } lfsl_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic err_fix;
    logic steer_p;
    logic steer_d;
    logic servo;
    logic wl_p;
    logic wl_i;
    logic wr_p;
    logic wr_i;
    logic out_load;
  } lfsl_cmd_t;

  typedef struct packed {
    logic div_done;
  } lfsl_stat_t;

endpackage

// ===== src/lfsl_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfsl_ctrl
// sequencer for one control tick
// ----------------------------------------------------------------------------
module lfsl_ctrl
  import lfsl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_free,
  input  lfsl_stat_t stat,
  output lfsl_cmd_t  cmd
);

  lfsl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_DIV;
      ST_DIV:       if (stat.div_done) state_nxt = ST_ERR;
      ST_ERR:       state_nxt = ST_STEER_P;
      ST_STEER_P:   state_nxt = ST_STEER_D;
      ST_STEER_D:   state_nxt = ST_SERVO;
      ST_SERVO:     state_nxt = ST_WHEEL_L_P;
      ST_WHEEL_L_P: state_nxt = ST_WHEEL_L_I;
      ST_WHEEL_L_I: state_nxt = ST_WHEEL_R_P;
      ST_WHEEL_R_P: state_nxt = ST_WHEEL_R_I;
      ST_WHEEL_R_I: state_nxt = ST_OUT;
      ST_OUT:       if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV:       cmd.div_step = 1'b1;
      ST_ERR:       cmd.err_fix  = 1'b1;
      ST_STEER_P:   cmd.steer_p  = 1'b1;
      ST_STEER_D:   cmd.steer_d  = 1'b1;
      ST_SERVO:     cmd.servo    = 1'b1;
      ST_WHEEL_L_P: cmd.wl_p     = 1'b1;
      ST_WHEEL_L_I: cmd.wl_i     = 1'b1;
      ST_WHEEL_R_P: cmd.wr_p     = 1'b1;
      ST_WHEEL_R_I: cmd.wr_i     = 1'b1;
      ST_OUT:       cmd.out_load = out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

// ===== src/lfsl_dp.sv =====
// ----------------------------------------------------------------------------
// lfsl_dp
// datapath: restoring divider, shared multiplier, state and output register
// ----------------------------------------------------------------------------
module lfsl_dp
  import lfsl_pkg::*;
#(
  parameter int PWM_MAX  = PWM_MAX_DEF,
  parameter int ADC_BITS = ADC_BITS_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  lfsl_cmd_t          cmd,
  output lfsl_stat_t         stat,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [11:0]        in_adc_left,
  input  logic [11:0]        in_adc_middle,
  input  logic [11:0]        in_adc_right,
  input  logic [15:0]        in_enc_left_count,
  input  logic [15:0]        in_enc_right_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_free,
  output logic [14:0]        out_servo_pulse,
  output logic [9:0]         out_pwm_left,
  output logic [9:0]         out_pwm_right,
  output logic signed [15:0] out_line_error,
  output logic               out_large_deviation
);

  localparam int PW    = $clog2(PWM_MAX + 1);
  localparam int ADC_W = (ADC_BITS < 12) ? ADC_BITS : 12;

  // configuration
  logic signed [15:0] base_r, skp_r, skd_r, vkp_r, vki_r;
  logic [14:0]        ctr_r, lo_r, hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 16'sd300;
      ctr_r  <= 15'd1500;
      lo_r   <= 15'd1000;
      hi_r   <= 15'd2000;
      skp_r  <= 16'sd2560;
      skd_r  <= 16'sd512;
      vkp_r  <= 16'sd154;
      vki_r  <= 16'sd0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_BASE_SPEED: base_r <= cfg_data;
        REG_SERVO_CTR:  ctr_r  <= cfg_data[14:0];
        REG_SERVO_LO:   lo_r   <= cfg_data[14:0];
        REG_SERVO_HI:   hi_r   <= cfg_data[14:0];
        REG_STEER_KP:   skp_r  <= cfg_data;
        REG_STEER_KD:   skd_r  <= cfg_data;
        REG_SPEED_KP:   vkp_r  <= cfg_data;
        REG_SPEED_KI:   vki_r  <= cfg_data;
        default:        base_r <= base_r;
      endcase
    end
  end

  // state
  logic signed [15:0] prev_err_r;
  logic signed [10:0] integ_l_r, integ_r_r;
  logic [15:0]        encp_l_r, encp_r_r;

  // working registers
  logic [15:0]        enc_l_r, enc_r_r;
  logic               neg_r;
  logic [13:0]        den_r;
  logic [27:0]        quo_r;
  logic [14:0]        rem_r;
  logic [4:0]         cnt_r;
  logic signed [16:0] e_r;
  logic               large_r;
  logic signed [7:0]  t_r;
  logic signed [40:0] acc_r;
  logic [14:0]        servo_r;
  logic [PW-1:0]      pwm_l_r, pwm_r_r;

  // outputs
  logic               ov_r;
  logic [14:0]        o_servo_r;
  logic [9:0]         o_pl_r, o_pr_r;
  logic signed [15:0] o_err_r;
  logic               o_large_r;

  logic [ADC_W-1:0] l_a, m_a, r_a;
  logic [13:0]      sum_w;
  logic [12:0]      diff_mag;
  assign l_a      = in_adc_left[ADC_W-1:0];
  assign m_a      = in_adc_middle[ADC_W-1:0];
  assign r_a      = in_adc_right[ADC_W-1:0];
  assign sum_w    = 14'(l_a) + 14'(m_a) + 14'(r_a);
  assign diff_mag = (r_a >= l_a) ? 13'(r_a - l_a) : 13'(l_a - r_a);

  // restoring divider step
  logic [15:0] trial;
  assign trial = {rem_r, quo_r[27]} - {2'b0, den_r};
  assign stat.div_done = (cnt_r == 5'd27);

  // shared multiplier, 17 x 16
  logic signed [16:0] ma;
  logic signed [15:0] mb;
  logic signed [32:0] prod;
  assign prod = ma * mb;

  logic signed [16:0] err_l, err_r;
  logic signed [15:0] tgt_l, tgt_r;
  assign tgt_l   = base_r - 16'(t_r);
  assign tgt_r   = base_r + 16'(t_r);
  assign err_l   = 17'(tgt_l) - 17'(signed'(enc_l_r - encp_l_r));
  assign err_r   = 17'(tgt_r) - 17'(signed'(enc_r_r - encp_r_r));

  logic signed [17:0] integ_sum;
  logic signed [10:0] integ_new;
  assign integ_sum = cmd.wl_p ? 18'(integ_l_r) + 18'(err_l) : 18'(integ_r_r) + 18'(err_r);
  always_comb begin
    if (integ_sum > 18'sd1000)       integ_new = 11'sd1000;
    else if (integ_sum < -18'sd1000) integ_new = -11'sd1000;
    else                             integ_new = 11'(integ_sum);
  end

  always_comb begin
    ma = '0;
    mb = '0;
    priority if (cmd.steer_p) begin
      ma = e_r;
      mb = skp_r;
    end else if (cmd.steer_d) begin
      ma = e_r - 17'(prev_err_r);
      mb = skd_r;
    end else if (cmd.wl_p) begin
      ma = err_l;
      mb = vkp_r;
    end else if (cmd.wr_p) begin
      ma = err_r;
      mb = vkp_r;
    end else if (cmd.wl_i) begin
      ma = 17'(integ_l_r);
      mb = vki_r;
    end else if (cmd.wr_i) begin
      ma = 17'(integ_r_r);
      mb = vki_r;
    end
  end

  // servo from acc
  logic signed [44:0] acc12;
  logic signed [44:0] off_w;
  logic signed [45:0] pulse_w;
  logic signed [45:0] lim_lo;
  assign acc12 = (45'(acc_r) <<< 3) + (45'(acc_r) <<< 2);
  assign off_w = (acc12 < 0) ? -((-acc12) >>> 23) : (acc12 >>> 23);
  assign pulse_w = large_r ? 46'($signed({1'b0, ctr_r})) + 46'(off_w)
                           : 46'($signed({1'b0, ctr_r}));
  assign lim_lo = (pulse_w < 46'($signed({1'b0, lo_r}))) ? 46'($signed({1'b0, lo_r})) : pulse_w;

  // pwm from proportional term in acc plus integral product
  logic signed [40:0] acc_sum;
  logic signed [40:0] delta;
  logic signed [17:0] bduty;
  logic signed [42:0] v_w;
  logic [PW-1:0]      pwm_w;
  assign acc_sum = acc_r + 41'(prod);
  assign delta = (acc_sum > 41'sd3840) ? 41'sd3840 :
                 (acc_sum < -41'sd3840) ? -41'sd3840 : acc_sum;
  assign bduty = (base_r < 0) ? 18'sd0 :
                 (18'(base_r) > 18'(PWM_MAX)) ? 18'(PWM_MAX) : 18'(base_r);
  assign v_w = (43'(bduty) <<< 8) + 43'(delta);
  always_comb begin
    if (v_w < 0)                        pwm_w = '0;
    else if ((v_w >>> 8) > 43'(PWM_MAX)) pwm_w = PW'(PWM_MAX);
    else                                pwm_w = PW'(v_w >>> 8);
  end

  // e from quotient
  logic [28:0] qs;
  logic [15:0] mag_w;
  assign qs = (quo_r > 28'd32767 && !neg_r) ? 29'd32767 : 29'(quo_r);
  assign mag_w = 16'(qs);

  // turn term
  logic signed [24:0] te;
  assign te = 25'(mag_w) * 25'sd120;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_l_r  <= '0;
      integ_r_r  <= '0;
      encp_l_r   <= '0;
      encp_r_r   <= '0;
      ov_r       <= 1'b0;
    end else begin
      if (cmd.wl_p) begin
        integ_l_r <= integ_new;
        encp_l_r  <= enc_l_r;
      end
      if (cmd.wr_p) begin
        integ_r_r <= integ_new;
        encp_r_r  <= enc_r_r;
      end
      if (cmd.steer_d && large_r) prev_err_r <= 16'(e_r);
      if (cmd.out_load)          ov_r <= 1'b1;
      else if (out_ready)        ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      enc_l_r <= in_enc_left_count;
      enc_r_r <= in_enc_right_count;
      neg_r   <= (l_a > r_a);
      den_r   <= sum_w;
      quo_r   <= (sum_w == '0) ? 28'd0 : {diff_mag[12:0], 15'd0};
      rem_r   <= '0;
      cnt_r   <= '0;
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r + 5'd1;
      if (!trial[15]) begin
        rem_r <= trial[14:0];
        quo_r <= {quo_r[26:0], 1'b1};
      end else begin
        rem_r <= {rem_r[13:0], quo_r[27]};
        quo_r <= {quo_r[26:0], 1'b0};
      end
    end
    if (cmd.err_fix) begin
      // zero sensor sum gives zero error
      if (den_r == '0 || mag_w <= 16'(DEADBAND_Q15)) begin
        e_r     <= '0;
        large_r <= 1'b0;
        t_r     <= '0;
      end else begin
        e_r     <= neg_r ? -17'(mag_w) : 17'(mag_w);
        large_r <= (mag_w >= 16'(THRESH_Q15));
        t_r     <= (mag_w >= 16'(THRESH_Q15)) ?
                   (neg_r ? -8'(te >>> 15) : 8'(te >>> 15)) : 8'sd0;
      end
    end
    if (cmd.steer_p) acc_r <= 41'(prod);
    if (cmd.steer_d) acc_r <= acc_r + 41'(prod);
    if (cmd.servo)   servo_r <= (lim_lo > 46'($signed({1'b0, hi_r}))) ? hi_r : 15'(lim_lo);
    if (cmd.wl_p || cmd.wr_p) acc_r <= 41'(prod);
    if (cmd.wl_i)    pwm_l_r <= pwm_w;
    if (cmd.wr_i)    pwm_r_r <= pwm_w;
    if (cmd.out_load) begin
      o_servo_r <= servo_r;
      o_pl_r    <= 10'(pwm_l_r);
      o_pr_r    <= 10'(pwm_r_r);
      o_err_r   <= 16'(e_r);
      o_large_r <= large_r;
    end
  end

  assign out_free            = !ov_r || out_ready;
  assign out_valid           = ov_r;
  assign out_servo_pulse     = o_servo_r;
  assign out_pwm_left        = o_pl_r;
  assign out_pwm_right       = o_pr_r;
  assign out_line_error      = o_err_r;
  assign out_large_deviation = o_large_r;

endmodule

// ===== src/line_follow_steer_speed_loop_unit.sv =====
// ----------------------------------------------------------------------------
// line_follow_steer_speed_loop_unit
// three sensor line follower: steering pd loop and two wheel pi speed loops
// ----------------------------------------------------------------------------
// channel  direction  handshake
// in_      input      in_valid / in_ready
// out_     output     out_valid / out_ready
// cfg_     input      cfg_write_en, no wait
// each request passes in order through accept, the restoring divider, the
// error fix, the steering terms and servo, the wheel terms and the load of
// the output register; a new request is accepted only back in idle.
// reset clears the loop state and loads register defaults.
// a waiting result stalls only the final load into the output register.
// ----------------------------------------------------------------------------
module line_follow_steer_speed_loop_unit
  import lfsl_pkg::*;
#(
  parameter int PWM_MAX  = PWM_MAX_DEF,
  parameter int ADC_BITS = ADC_BITS_DEF
)(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [11:0]        in_adc_left,
  input  logic [11:0]        in_adc_middle,
  input  logic [11:0]        in_adc_right,
  input  logic [15:0]        in_enc_left_count,
  input  logic [15:0]        in_enc_right_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        out_servo_pulse,
  output logic [9:0]         out_pwm_left,
  output logic [9:0]         out_pwm_right,
  output logic signed [15:0] out_line_error,
  output logic               out_large_deviation
);

  lfsl_cmd_t  cmd;
  lfsl_stat_t stat;
  logic       out_free;

  lfsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfsl_dp #(
    .PWM_MAX  (PWM_MAX),
    .ADC_BITS (ADC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_adc_left         (in_adc_left),
    .in_adc_middle       (in_adc_middle),
    .in_adc_right        (in_adc_right),
    .in_enc_left_count   (in_enc_left_count),
    .in_enc_right_count  (in_enc_right_count),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_free            (out_free),
    .out_servo_pulse     (out_servo_pulse),
    .out_pwm_left        (out_pwm_left),
    .out_pwm_right       (out_pwm_right),
    .out_line_error      (out_line_error),
    .out_large_deviation (out_large_deviation)
  );

endmodule

// ===== tb/line_follow_steer_speed_loop_unit_test.sv =====
// ----------------------------------------------------------------------------
// line_follow_steer_speed_loop_unit_test
// drives sensor and encoder requests into the steering and wheel speed loop,
// predicts every result with a behavioral copy of the control tick and checks
// each result field by field, across several register settings and stalls
// ----------------------------------------------------------------------------
module line_follow_steer_speed_loop_unit_test
  import lfsl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] adc_l;
    logic [11:0] adc_m;
    logic [11:0] adc_r;
    logic [15:0] enc_l;
    logic [15:0] enc_r;
  } tick_t;

  typedef struct packed {
    logic [14:0] servo;
    logic [9:0]  pwm_l;
    logic [9:0]  pwm_r;
    logic [15:0] err;
    logic        dev;
  } command_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_write_en = 1'b0;
  logic [2:0] cfg_index = REG_BASE_SPEED;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [11:0] in_adc_left = '0, in_adc_middle = '0, in_adc_right = '0;
  logic [15:0] in_enc_left_count = '0, in_enc_right_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [14:0] out_servo_pulse;
  logic [9:0] out_pwm_left, out_pwm_right;
  logic signed [15:0] out_line_error;
  logic out_large_deviation;

  line_follow_steer_speed_loop_unit dut (.*);

  always #5 clk = ~clk;

  tick_t pending_ticks[$];
  command_t expected_cmds[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  longint cycles = 0;
  bit hold_sender = 1'b0;

  logic [15:0] regs[8];
  longint prev_err, integ_l, integ_r;
  longint enc_prev_l, enc_prev_r;

  function automatic longint sx16(longint v);
    v = v & 64'hFFFF;
    return (v >= 32768) ? v - 65536 : v;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic longint servo_clip(longint p);
    if (p < longint'(regs[2][14:0])) p = regs[2][14:0];
    if (p > longint'(regs[3][14:0])) p = regs[3][14:0];
    return p;
  endfunction

  task automatic wheel_pwm(input longint count, inout longint prev, inout longint integ,
                           input longint target, input longint duty, output logic [9:0] pwm);
    longint spd, er, acc, v;
    spd = sx16(count - prev);
    er = target - spd;
    prev = count & 64'hFFFF;
    integ = clip(integ + er, -INTEG_LIMIT, INTEG_LIMIT);
    acc = sx16(regs[6]) * er + sx16(regs[7]) * integ;
    acc = clip(acc, -DELTA_LIMIT, DELTA_LIMIT);
    v = duty * 256 + acc;
    if (v < 0) v = 0;
    else v = v / 256;
    if (v > PWM_MAX_DEF) v = PWM_MAX_DEF;
    pwm = v[9:0];
  endtask

  task automatic predict_tick(input tick_t t);
    longint l, m, r, sum, e, mag, base, duty, turn, acc, servo;
    command_t c;
    l = t.adc_l; m = t.adc_m; r = t.adc_r;
    sum = l + m + r;
    e = 0;
    turn = 0;
    base = sx16(regs[0]);
    duty = clip(base, 0, PWM_MAX_DEF);
    if (sum > 0) begin
      e = ((r - l) * 32768) / sum;
      if (e > 32767) e = 32767;
    end
    mag = (e < 0) ? -e : e;
    if (mag <= DEADBAND_Q15) begin
      e = 0;
      mag = 0;
    end
    c.dev = (mag >= THRESH_Q15);
    if (c.dev) begin
      acc = sx16(regs[4]) * e + sx16(regs[5]) * (e - prev_err);
      prev_err = e;
      turn = (e * 120) / 32768;
      servo = servo_clip(longint'(regs[1][14:0]) + (acc * 12) / 8388608);
    end else begin
      servo = servo_clip(longint'(regs[1][14:0]));
    end
    c.servo = servo[14:0];
    wheel_pwm(t.enc_l, enc_prev_l, integ_l, sx16(base - turn), duty, c.pwm_l);
    wheel_pwm(t.enc_r, enc_prev_r, integ_r, sx16(base + turn), duty, c.pwm_r);
    c.err = e[15:0];
    expected_cmds.push_back(c);
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        accepted <= accepted + 1;
        predict_tick({in_adc_left, in_adc_middle, in_adc_right,
                      in_enc_left_count, in_enc_right_count});
        in_valid <= 1'b0;
        send_gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!hold_sender && pending_ticks.size() > 0) begin
          tick_t t;
          t = pending_ticks.pop_front();
          in_adc_left <= t.adc_l;
          in_adc_middle <= t.adc_m;
          in_adc_right <= t.adc_r;
          in_enc_left_count <= t.enc_l;
          in_enc_right_count <= t.enc_r;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        command_t got, exp_c;
        got = {out_servo_pulse, out_pwm_left, out_pwm_right, out_line_error,
               out_large_deviation};
        if (expected_cmds.size() == 0) begin
          $display("%0t: result with no request pending, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          exp_c = expected_cmds.pop_front();
          checked <= checked + 1;
          if (got !== exp_c) begin
            $display("%0t: servo exp %0d act %0d, pwm_l exp %0d act %0d, pwm_r exp %0d act %0d",
                     $time, exp_c.servo, got.servo, exp_c.pwm_l, got.pwm_l,
                     exp_c.pwm_r, got.pwm_r);
            $display("%0t: line_error exp %0d act %0d, deviation exp %0d act %0d", $time,
                     $signed(exp_c.err), $signed(got.err), exp_c.dev, got.dev);
            errors <= errors + 1;
          end
        end
        recv_gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
        out_ready <= (recv_gap == 0);
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= (recv_gap == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 1000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    regs[idx] = (idx >= REG_SERVO_CTR && idx <= REG_SERVO_HI) ? {1'b0, val[14:0]} : val;
  endtask

  task automatic drain();
    while (pending_ticks.size() > 0 || in_valid || expected_cmds.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  logic [15:0] enc_track_l = 0, enc_track_r = 0;

  function automatic tick_t rand_tick(int mode);
    tick_t t;
    t.enc_l = 16'($urandom);
    t.enc_r = 16'($urandom);
    t.adc_l = 12'($urandom); t.adc_m = 12'($urandom); t.adc_r = 12'($urandom);
    case (mode)
      0: begin
        t.adc_l = 12'($urandom_range(0, 300)); t.adc_m = 12'($urandom_range(0, 300));
      end
      1: begin
        t.adc_r = 12'($urandom_range(0, 300)); t.adc_m = 12'($urandom_range(0, 300));
      end
      2: begin
        t.adc_m = 12'($urandom_range(0, 4095)); t.adc_l = 12'($urandom_range(0, 50));
        t.adc_r = 12'($urandom_range(0, 50));
      end
      default: ;
    endcase
    if (mode != 3) begin
      t.enc_l = 16'(enc_track_l + $urandom_range(0, 700) - 300);
      t.enc_r = 16'(enc_track_r + $urandom_range(0, 700) - 300);
    end
    enc_track_l = t.enc_l;
    enc_track_r = t.enc_r;
    return t;
  endfunction

  task automatic add(input logic [11:0] l, m, r, input logic [15:0] el, er);
    pending_ticks.push_back({l, m, r, el, er});
    enc_track_l = el;
    enc_track_r = er;
  endtask

  initial begin
    regs[0] = 300; regs[1] = 1500; regs[2] = 1000; regs[3] = 2000;
    regs[4] = 2560; regs[5] = 512; regs[6] = 154; regs[7] = 0;
    prev_err = 0; integ_l = 0; integ_r = 0; enc_prev_l = 0; enc_prev_r = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero sum, full scale, deadband, threshold, encoder wrap
    add(0, 0, 0, 0, 0);
    add(0, 0, 4095, 300, 300);
    add(4095, 0, 0, 600, 600);
    add(4095, 4095, 4095, 900, 900);
    add(100, 3000, 130, 1200, 1200);
    add(1000, 2000, 1700, 1500, 1500);
    add(1000, 2000, 1800, 65535, 0);
    add(4095, 4095, 0, 10, 65000);
    add(0, 4095, 4095, 32767, 32768);
    add(12'hAAA, 12'h555, 12'hFFF, 16'hAAAA, 16'h5555);
    add(12'h555, 12'hAAA, 12'h000, 16'h5555, 16'hAAAA);
    add(1, 0, 0, 0, 0);
    drain();

    write_reg(REG_SERVO_LO, 1800);
    write_reg(REG_SERVO_HI, 1200);
    write_reg(REG_STEER_KP, 16'h7FFF);
    write_reg(REG_STEER_KD, 16'h8000);
    write_reg(REG_SPEED_KI, 16'h0100);
    add(0, 0, 4095, 100, 100);
    add(4095, 0, 0, 200, 200);
    add(0, 0, 0, 50000, 9);
    for (int i = 0; i < 350; i++) pending_ticks.push_back(rand_tick($urandom_range(0, 3)));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_BASE_SPEED, 16'h8000);
          write_reg(REG_SERVO_CTR, 16'h7FFF);
          write_reg(REG_SERVO_LO, 0);
          write_reg(REG_SERVO_HI, 20000);
          write_reg(REG_SPEED_KP, 16'h7FFF);
          write_reg(REG_SPEED_KI, 16'h8000);
        end
        1: begin
          write_reg(REG_BASE_SPEED, 16'h7FFF);
          write_reg(REG_SERVO_CTR, 0);
          write_reg(REG_STEER_KP, 16'h8000);
          write_reg(REG_STEER_KD, 16'h7FFF);
          write_reg(REG_SPEED_KP, 16'h8000);
          write_reg(REG_SPEED_KI, 16'h7FFF);
        end
        2: begin
          write_reg(REG_BASE_SPEED, 998);
          write_reg(REG_SERVO_CTR, 1500);
          write_reg(REG_SERVO_LO, 500);
          write_reg(REG_SERVO_HI, 2500);
          write_reg(REG_STEER_KP, 16'($urandom));
          write_reg(REG_STEER_KD, 16'($urandom));
          write_reg(REG_SPEED_KP, 16'($urandom_range(0, 600)));
          write_reg(REG_SPEED_KI, 16'($urandom_range(0, 40)));
        end
        default: begin
          write_reg(REG_BASE_SPEED, 16'($urandom_range(0, 999)));
          write_reg(REG_SERVO_CTR, 16'($urandom_range(0, 20000)));
          write_reg(REG_SERVO_LO, 16'($urandom_range(0, 20000)));
          write_reg(REG_SERVO_HI, 16'($urandom_range(0, 20000)));
          write_reg(REG_STEER_KP, 16'($urandom));
          write_reg(REG_STEER_KD, 16'($urandom));
          write_reg(REG_SPEED_KP, 16'($urandom));
          write_reg(REG_SPEED_KI, 16'($urandom));
        end
      endcase
      for (int i = 0; i < 310; i++) pending_ticks.push_back(rand_tick($urandom_range(0, 3)));
      if (phase == 2) begin
        // sender holds until every result is back
        while (pending_ticks.size() > 150) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_cmds.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end

    $display("sent %0d requests and checked %0d results over six register settings",
             accepted, checked);
    $display("covered zero sum, full scale, deadband, servo limit crossing, encoder wrap");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
